@@ hdl/ptp_odc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_pkg
// Shared types, constants and helpers of the PTP offset / delay calculator.
// ----------------------------------------------------------------------------
package ptp_odc_pkg;

  localparam int AvgLen   = 10;
  localparam int CntW     = $clog2(AvgLen + 1);
  localparam int SlotW    = (AvgLen > 1) ? $clog2(AvgLen) : 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam logic [63:0] NsPerSec = 64'd1000000000;

  typedef enum logic [2:0] {
    REQ_SYNC      = 3'd0,
    REQ_DELAY     = 3'd1,
    REQ_PEER      = 3'd2,
    REQ_AVG_RESET = 3'd3,
    REQ_STEP      = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_LOCAL_UTC  = 3'd0,
    CFG_MASTER_PTP = 3'd1,
    CFG_UTC_VALID  = 3'd2,
    CFG_TRACEABLE  = 3'd3,
    CFG_ANN_OFFSET = 3'd4,
    CFG_MIN_OFFSET = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [62:0] origin_ns;
    logic [62:0] ingress_ns;
    logic [63:0] sync_corr;
    logic [63:0] followup_corr;
    logic [62:0] req_tx_ns;
    logic [62:0] req_rx_ns;
    logic [63:0] resp_corr;
    logic [63:0] peer_delay_ns;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] offset_ns;
    logic [63:0] mean_delay_ns;
    logic        offset_ready;
    logic        delay_taken;
    logic        negative_delay;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture item
    CMD_SYNC_A,    // corrections sum
    CMD_SYNC_B,    // offset base
    CMD_SYNC_MUL,  // seconds * 1e9 low half
    CMD_SYNC_ADD,  // add correction
    CMD_DLY_A,     // raw delay
    CMD_DLY_B,     // halve, window read
    CMD_DLY_C,     // update sum, write window
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_END,
    CMD_OTHER,
    CMD_RESULT
  } dp_cmd_e;

  typedef struct packed {
    logic sync_valid;
    logic utc_apply;
    logic div_last;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SYNC,
    ST_DELAY,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  // ns*2^16 correction to ns, arithmetic shift
  function automatic logic [63:0] corr_to_ns(input logic [63:0] x);
    corr_to_ns = {{16{x[63]}}, x[63:16]};
  endfunction

endpackage

@@ hdl/ptp_odc_if.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ptp_odc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ptp_odc_ram.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module ptp_odc_ram #(
  parameter int Width = 64,
  parameter int Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ hdl/ptp_odc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_ctrl
// Sequencer: steps the datapath through one request.
// ----------------------------------------------------------------------------
module ptp_odc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [2:0]             in_type_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ptp_odc_pkg::dp_status_t status_i,
  output ptp_odc_pkg::dp_cmd_e   cmd_o
);
  import ptp_odc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [2:0]  type_q, type_d;
  logic [1:0]  step_q, step_d;
  logic        ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      type_q   <= 3'd0;
      step_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      type_q   <= type_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    type_d     = type_q;
    step_d     = step_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          type_d  = in_type_i;
          step_d  = 2'd0;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (type_q)
          REQ_SYNC: state_d = ST_SYNC;
          REQ_DELAY: begin
            if (status_i.sync_valid) begin
              state_d = ST_DELAY;
            end else begin
              state_d = ST_OUT;
            end
          end
          default: begin
            cmd_o   = CMD_OTHER;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_SYNC: begin
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0: cmd_o = CMD_SYNC_A;
          2'd1: cmd_o = CMD_SYNC_B;
          2'd2: cmd_o = CMD_SYNC_MUL;
          default: begin
            if (status_i.utc_apply) begin
              cmd_o = CMD_SYNC_ADD;
            end
            state_d = ST_OUT;
          end
        endcase
      end
      ST_DELAY: begin
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0: cmd_o = CMD_DLY_A;
          2'd1: cmd_o = CMD_DLY_B;
          2'd2: cmd_o = CMD_DLY_C;
          default: begin
            cmd_o   = CMD_DIV_START;
            state_d = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          cmd_o   = CMD_DIV_END;
          state_d = ST_OUT;
        end else begin
          cmd_o = CMD_DIV_STEP;
        end
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!ovalid_q || out_ready_i) begin
          cmd_o    = CMD_RESULT;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

@@ hdl/ptp_odc_dp.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_dp
// Datapath: saved sync, offset/delay registers, window, restoring divider.
// ----------------------------------------------------------------------------
module ptp_odc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ptp_odc_pkg::in_item_t   in_i,
  input  ptp_odc_pkg::cfg_wr_t    cfg_i,
  input  logic                    cfg_we_i,
  input  ptp_odc_pkg::dp_cmd_e    cmd_i,
  output ptp_odc_pkg::dp_status_t status_o,
  output ptp_odc_pkg::out_item_t  out_o
);
  import ptp_odc_pkg::*;

  // configuration
  logic        local_utc_q, master_ptp_q, utc_valid_q, traceable_q;
  logic [15:0] ann_q;
  logic [7:0]  min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_utc_q  <= 1'b0;
      master_ptp_q <= 1'b0;
      utc_valid_q  <= 1'b0;
      traceable_q  <= 1'b0;
      ann_q        <= 16'd37;
      min_q        <= 8'd37;
    end else if (cfg_we_i) begin
      unique case (cfg_i.idx)
        CFG_LOCAL_UTC:  local_utc_q  <= cfg_i.data[0];
        CFG_MASTER_PTP: master_ptp_q <= cfg_i.data[0];
        CFG_UTC_VALID:  utc_valid_q  <= cfg_i.data[0];
        CFG_TRACEABLE:  traceable_q  <= cfg_i.data[0];
        CFG_ANN_OFFSET: ann_q        <= cfg_i.data;
        CFG_MIN_OFFSET: min_q        <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // UTC seconds, signed 17-bit
  logic signed [16:0] ann_s, min_s, secs;
  assign ann_s = {ann_q[15], ann_q};
  assign min_s = {9'd0, min_q};
  always_comb begin
    if (utc_valid_q && traceable_q) begin
      secs = ann_s;
    end else if (ann_s > min_s) begin
      secs = ann_s;
    end else begin
      secs = min_s;
    end
  end

  // state
  in_item_t    item_q;
  logic [63:0] org_q, ing_q, csum_q, off_q, dly_q, sum_q, tmp_q, corr_q;
  logic        sv_q, neg_q, taken_q;
  logic [CntW-1:0]  cnt_q;
  logic [SlotW-1:0] next_q;
  logic [63:0] rem_q, quo_q, win_rd;
  logic [6:0]  bit_q;
  logic        dneg_q;
  logic        win_we;
  logic [63:0] prod_q;

  assign win_we = (cmd_i == CMD_DLY_C);

  ptp_odc_ram #(.Width(64), .Depth(AvgLen)) u_win (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .addr_i (next_q),
    .wdata_i(tmp_q),
    .rdata_o(win_rd)
  );

  // restoring divide step
  logic [64:0] trial;
  assign trial = {rem_q, quo_q[63]} - {{(65-CntW){1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: item_q <= in_i;
      CMD_SYNC_A: corr_q <= corr_to_ns(item_q.sync_corr)
                          + corr_to_ns(item_q.followup_corr);
      CMD_SYNC_MUL: prod_q <= 64'($signed(secs)) * NsPerSec;
      CMD_DLY_A: tmp_q <= ((ing_q - {1'b0, item_q.req_tx_ns})
                         + ({1'b0, item_q.req_rx_ns} - org_q))
                         - (csum_q + corr_to_ns(item_q.resp_corr));
      CMD_DLY_B: tmp_q <= $signed(tmp_q + {63'd0, tmp_q[63]}) >>> 1;
      CMD_DLY_C: tmp_q <= sum_q;
      CMD_DIV_START: begin
        dneg_q <= sum_q[63];
        quo_q  <= sum_q[63] ? (~sum_q + 64'd1) : sum_q;
        rem_q  <= 64'd0;
        bit_q  <= 7'd0;
      end
      CMD_DIV_STEP: begin
        bit_q <= bit_q + 7'd1;
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], quo_q[63]};
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign status_o.sync_valid = sv_q;
  assign status_o.utc_apply  = local_utc_q && master_ptp_q;
  assign status_o.div_last   = (bit_q == 7'd64);

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q   <= '0;
      ing_q   <= '0;
      csum_q  <= '0;
      sv_q    <= 1'b0;
      off_q   <= '0;
      dly_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      next_q  <= '0;
      neg_q   <= 1'b0;
      taken_q <= 1'b0;
      out_o   <= '0;
    end else begin
      case (cmd_i)
        CMD_LOAD: begin
          neg_q   <= 1'b0;
          taken_q <= 1'b0;
        end
        CMD_SYNC_B: begin
          org_q  <= {1'b0, item_q.origin_ns};
          ing_q  <= {1'b0, item_q.ingress_ns};
          csum_q <= corr_q;
          sv_q   <= 1'b1;
          off_q  <= {1'b0, item_q.ingress_ns}
                    - ({1'b0, item_q.origin_ns} + dly_q + corr_q);
        end
        CMD_SYNC_ADD: off_q <= off_q + prod_q;
        CMD_DLY_B: begin
          neg_q   <= tmp_q[63] && (tmp_q != 64'hFFFF_FFFF_FFFF_FFFF);
          taken_q <= 1'b1;
        end
        CMD_DLY_C: begin
          // window read data for next_q is valid here
          if (32'(cnt_q) >= AvgLen) begin
            sum_q <= sum_q - win_rd + tmp_q;
          end else begin
            sum_q <= sum_q + tmp_q;
            cnt_q <= cnt_q + CntW'(1);
          end
          next_q <= (32'(next_q) + 1 >= AvgLen) ? '0 : next_q + SlotW'(1);
        end
        CMD_DIV_END: dly_q <= dneg_q ? (~quo_q + 64'd1) : quo_q;
        CMD_OTHER: begin
          case (item_q.req_type)
            REQ_PEER: dly_q <= item_q.peer_delay_ns;
            REQ_AVG_RESET: begin
              sum_q  <= '0;
              cnt_q  <= '0;
              next_q <= '0;
            end
            REQ_STEP: begin
              org_q  <= '0;
              ing_q  <= '0;
              csum_q <= '0;
              sv_q   <= 1'b0;
            end
            default: ;
          endcase
        end
        CMD_RESULT: begin
          out_o.kind           <= item_q.req_type;
          out_o.offset_ns      <= off_q;
          out_o.mean_delay_ns  <= dly_q;
          out_o.offset_ready   <= (dly_q != 64'd0);
          out_o.delay_taken    <= taken_q;
          out_o.negative_delay <= neg_q;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hdl/ptp_offset_delay_calculator_unit.sv @@
// ----------------------------------------------------------------------------
// ptp_offset_delay_calculator_unit
// PTP offset from master and averaged mean path delay.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_req    sink       in_item_t (request type, timestamps, corrections)
// out_res   source     out_item_t (offset, mean delay, flags)
// cfg_wr    sink       cfg_wr_t (register index, write data)
//
// One request at a time, through dispatch to the result: peer delay, reset
// average, clock step, ignored and unknown requests directly; sync through
// corrections sum, offset base, product and UTC add; a taken delay response
// through the window update and the 64-step shift/subtract divider by the
// sample count. A stalled result holds the output register; the next result
// waits behind it. Reset is asynchronous, active low.
module ptp_offset_delay_calculator_unit (
  input logic clk_i,
  input logic rst_ni,
  ptp_odc_if.sink   in_req,
  ptp_odc_if.source out_res,
  ptp_odc_if.sink   cfg_wr
);
  import ptp_odc_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;

  assign cfg_wr.ready = 1'b1;

  ptp_odc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .in_type_i  (in_req.data.req_type),
    .in_ready_o (in_req.ready),
    .out_valid_o(out_res.valid),
    .out_ready_i(out_res.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptp_odc_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_req.data),
    .cfg_i   (cfg_wr.data),
    .cfg_we_i(cfg_wr.valid),
    .cmd_i   (cmd),
    .status_o(status),
    .out_o   (out_res.data)
  );
endmodule

@@ hdl/ptp_odc_checker.sv @@
// ----------------------------------------------------------------------------
// ptp_odc_checker
// Port-level checks on request/result ordering.
// ----------------------------------------------------------------------------
module ptp_odc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  // no request taken in the cycle right after another
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("back-to-back accept");
  // a result never appears the cycle after a request
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("early result");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
endmodule

bind ptp_offset_delay_calculator_unit ptp_odc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_req.valid), .in_ready_i(in_req.ready),
  .out_valid_i(out_res.valid), .out_ready_i(out_res.ready)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the PTP offset / mean path delay calculator: directed table of
// requests and UTC offset extremes, then random request sequences, mostly sync /
// delay response, under varying handshake idling, each result compared against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptp_odc_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int NumRows    = 22;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptp_odc_if #(.T(in_item_t))  in_req ();
  ptp_odc_if #(.T(out_item_t)) out_res ();
  ptp_odc_if #(.T(cfg_wr_t))   cfg_wr ();

  ptp_offset_delay_calculator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic        pr_utc, pr_ptp, pr_valid, pr_trace;
  logic [15:0] pr_ann;
  logic [7:0]  pr_min;
  logic [63:0] pr_org, pr_ing, pr_csum, pr_off, pr_dly, pr_sum;
  logic        pr_sync;
  logic [63:0] pr_win [AvgLen];
  int          pr_cnt, pr_next;

  out_item_t expected_q [$];
  int errors = 0;
  int idle_in_pct = 0, idle_out_pct = 0;
  int watch = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] sdiv(input logic [63:0] x, input logic [63:0] d);
    if (x[63]) return -((-x) / d);
    return x / d;
  endfunction

  function automatic logic [63:0] utc_secs();
    logic signed [63:0] ann, lo;
    ann = {{48{pr_ann[15]}}, pr_ann};
    lo = {56'd0, pr_min};
    if (pr_valid && pr_trace) return ann;
    return (ann > lo) ? ann : lo;
  endfunction

  function automatic out_item_t predict(input in_item_t r);
    out_item_t o;
    logic [63:0] pd;
    int slot;
    o = '0;
    case (r.req_type)
      REQ_SYNC: begin
        pr_org = {1'b0, r.origin_ns};
        pr_ing = {1'b0, r.ingress_ns};
        pr_csum = corr_to_ns(r.sync_corr) + corr_to_ns(r.followup_corr);
        pr_sync = 1'b1;
        pr_off = pr_ing - (pr_org + pr_dly + pr_csum);
        if (pr_utc && pr_ptp) pr_off += utc_secs() * NsPerSec;
      end
      REQ_DELAY: if (pr_sync) begin
        pd = (pr_ing - {1'b0, r.req_tx_ns}) + ({1'b0, r.req_rx_ns} - pr_org);
        pd -= pr_csum + corr_to_ns(r.resp_corr);
        pd = sdiv(pd, 64'd2);
        o.negative_delay = pd[63];
        o.delay_taken = 1'b1;
        slot = (pr_next >= AvgLen) ? 0 : pr_next;
        if (pr_cnt >= AvgLen) pr_sum -= pr_win[slot];
        else pr_cnt++;
        pr_win[slot] = pd;
        pr_sum += pd;
        pr_next = (slot + 1 >= AvgLen) ? 0 : slot + 1;
        pr_dly = sdiv(pr_sum, 64'(pr_cnt));
      end
      REQ_PEER: pr_dly = r.peer_delay_ns;
      REQ_AVG_RESET: begin
        pr_sum = '0; pr_cnt = 0; pr_next = 0;
      end
      REQ_STEP: begin
        pr_org = '0; pr_ing = '0; pr_csum = '0; pr_sync = 1'b0;
      end
      default: ;
    endcase
    o.kind = r.req_type;
    o.offset_ns = pr_off;
    o.mean_delay_ns = pr_dly;
    o.offset_ready = (pr_dly != 0);
    return o;
  endfunction

  // predict at acceptance: push expectation
  task automatic issue(input in_item_t r);
    out_item_t e;
    in_item_t c;
    c = r;
    while (idle_in_pct > 0 && $urandom_range(99) < idle_in_pct) @(posedge clk_i);
    in_req.valid <= 1'b1;
    in_req.data <= c;
    do @(posedge clk_i); while (!in_req.ready);
    e = predict(c);
    expected_q.push_back(e);
    in_req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data <= '{idx: idx, data: val};
    do @(posedge clk_i); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    case (idx)
      CFG_LOCAL_UTC:  pr_utc = val[0];
      CFG_MASTER_PTP: pr_ptp = val[0];
      CFG_UTC_VALID:  pr_valid = val[0];
      CFG_TRACEABLE:  pr_trace = val[0];
      CFG_ANN_OFFSET: pr_ann = val;
      CFG_MIN_OFFSET: pr_min = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_regs();
    write_reg(CFG_LOCAL_UTC, 16'($urandom_range(1)));
    write_reg(CFG_MASTER_PTP, 16'($urandom_range(1)));
    write_reg(CFG_UTC_VALID, 16'($urandom_range(1)));
    write_reg(CFG_TRACEABLE, 16'($urandom_range(1)));
    write_reg(CFG_ANN_OFFSET, 16'($urandom));
    write_reg(CFG_MIN_OFFSET, 16'($urandom_range(255)));
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t rand_item(input logic [2:0] t);
    in_item_t r;
    logic [63:0] base;
    r = '0;
    r.req_type = t;
    base = rnd64() >> $urandom_range(63);
    r.origin_ns = 63'(base + ($urandom_range(3) == 0 ? rnd64() : 64'($urandom_range(5000))));
    r.ingress_ns = 63'(base + $urandom_range(100000));
    r.req_tx_ns = 63'(base + $urandom_range(200000));
    r.req_rx_ns = 63'(base + $urandom_range(300000));
    r.sync_corr = ($urandom_range(3) == 0) ? rnd64() : 64'(signed'($urandom_range(2000000)) - 1000000);
    r.followup_corr = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(999999));
    r.resp_corr = ($urandom_range(3) == 0) ? rnd64() : 64'(-$urandom_range(999999));
    r.peer_delay_ns = ($urandom_range(1) == 0) ? rnd64() : 64'($urandom_range(5000));
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_item_t g, e;
    if (out_res.valid && out_res.ready) begin
      g = out_res.data;
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(g.kind), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (g.kind !== e.kind) report("kind", 64'(g.kind), 64'(e.kind));
        if (g.offset_ns !== e.offset_ns) report("offset_ns", g.offset_ns, e.offset_ns);
        if (g.mean_delay_ns !== e.mean_delay_ns)
          report("mean_delay_ns", g.mean_delay_ns, e.mean_delay_ns);
        if (g.offset_ready !== e.offset_ready)
          report("offset_ready", 64'(g.offset_ready), 64'(e.offset_ready));
        if (g.delay_taken !== e.delay_taken)
          report("delay_taken", 64'(g.delay_taken), 64'(e.delay_taken));
        if (g.negative_delay !== e.negative_delay)
          report("negative_delay", 64'(g.negative_delay), 64'(e.negative_delay));
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) out_res.ready <= 1'b0;
    else out_res.ready <= !(idle_out_pct > 0 && $urandom_range(99) < idle_out_pct);
  end

  // watchdog: cycles without any acceptance while a request or result is pending
  always @(posedge clk_i) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready) || (rst_ni && expected_q.size() == 0 && !in_req.valid))
      watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed rows: type, t1, t2, sync corr, fup corr, t3, t4, resp corr, peer
  in_item_t rows [NumRows];

  initial begin
    in_item_t r;
    int phase;
    in_req.valid = 1'b0;
    in_req.data = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.data = '0;
    pr_utc = 0; pr_ptp = 0; pr_valid = 0; pr_trace = 0;
    pr_ann = 16'd37; pr_min = 8'd37;
    pr_org = '0; pr_ing = '0; pr_csum = '0; pr_off = '0; pr_dly = '0; pr_sum = '0;
    pr_sync = 1'b0; pr_cnt = 0; pr_next = 0;
    foreach (pr_win[i]) pr_win[i] = '0;

    rows[0]  = '{REQ_DELAY, 63'd5, 63'd7, 0, 0, 63'd1, 63'd2, 0, 0}; // ignored: no sync
    rows[1]  = '{3'd5, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[2]  = '{3'd7, '1, '1, '1, '1, '1, '1, '1, '1};
    rows[3]  = '{REQ_SYNC, 63'd1000, 63'd1500, 64'h0000_0000_0001_0000,
                 64'hFFFF_FFFF_FFFF_0000, 0, 0, 0, 0};
    rows[4]  = '{REQ_DELAY, 0, 0, 0, 0, 63'd1600, 63'd1200, 64'h8000_0000_0000_0000, 0};
    rows[5]  = '{REQ_DELAY, 0, 0, 0, 0, 63'd9999, 63'd1001, 0, 0}; // negative delay
    rows[6]  = '{REQ_SYNC, '1, 63'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0, 0, 0, 0};
    rows[7]  = '{REQ_DELAY, 0, 0, 0, 0, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF, 0};
    rows[8]  = '{REQ_PEER, 0, 0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000};
    rows[9]  = '{REQ_PEER, 0, 0, 0, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF};
    rows[10] = '{REQ_PEER, 0, 0, 0, 0, 0, 0, 0, 64'd0};
    rows[11] = '{REQ_SYNC, 63'd0, '1, 0, 0, 0, 0, 0, 0};
    rows[12] = '{REQ_AVG_RESET, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[13] = '{REQ_DELAY, 0, 0, 0, 0, 63'd0, 63'd0, 0, 0};
    rows[14] = '{REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[15] = '{REQ_DELAY, 0, 0, 0, 0, 63'd3, 63'd4, 0, 0}; // ignored after step
    rows[16] = '{3'd6, 0, 0, 0, 0, 0, 0, 0, 0};
    rows[17] = '{REQ_SYNC, 63'd100, 63'd300, 0, 0, 0, 0, 0, 0};
    for (int i = 18; i < NumRows; i++) rows[i] = '{REQ_DELAY, 0, 0, 0, 0, 63'(i), 63'(i*7), 0, 0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; first expectation also checked against the reset values
    foreach (rows[i]) begin
      issue(rows[i]);
      if (i == 0 && (expected_q[0].delay_taken !== 1'b0 || expected_q[0].mean_delay_ns !== 0))
        report("reset state", 64'(expected_q[0].delay_taken), 64'd0);
    end
    drain();

    // UTC correction: extremes of the announced and minimum offsets
    write_reg(CFG_LOCAL_UTC, 16'd1);
    write_reg(CFG_MASTER_PTP, 16'd1);
    write_reg(CFG_UTC_VALID, 16'd1);
    write_reg(CFG_TRACEABLE, 16'd1);
    write_reg(CFG_ANN_OFFSET, 16'h8000);
    write_reg(CFG_MIN_OFFSET, 16'd255);
    issue(rand_item(REQ_SYNC));
    drain();
    write_reg(CFG_TRACEABLE, 16'd0);
    issue(rand_item(REQ_SYNC));
    drain();
    write_reg(CFG_ANN_OFFSET, 16'h7FFF);
    write_reg(CFG_MIN_OFFSET, 16'd0);
    issue(rand_item(REQ_SYNC));
    drain();

    // random part in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      idle_in_pct = (phase == 0) ? 28 : (phase == 1) ? 66 : 0;
      idle_out_pct = (phase == 0) ? 66 : (phase == 1) ? 28 : 0;
      set_regs();
      for (int n = 0; n < 280; n++) begin
        case ($urandom_range(19))
          0: r = rand_item(REQ_PEER);
          1: r = rand_item(REQ_AVG_RESET);
          2: r = rand_item(REQ_STEP);
          3: r = rand_item(3'($urandom_range(7)));
          4, 5, 6, 7: r = rand_item(REQ_SYNC);
          default: r = rand_item(REQ_DELAY);
        endcase
        issue(r);
        // sender waits for every outstanding result now and then
        if (n % 97 == 50) while (expected_q.size() != 0) @(posedge clk_i);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ptp_odc_pkg.sv
hdl/ptp_odc_if.sv
hdl/ptp_odc_ram.sv
hdl/ptp_odc_ctrl.sv
hdl/ptp_odc_dp.sv
hdl/ptp_offset_delay_calculator_unit.sv
hdl/ptp_odc_checker.sv
tb/testbench.sv
